// File: sv/fmp_pkg.sv
// fmp_pkg: shared types and constants for the fractional max pooling engine.
// Item op codes, register indexes, cell word layout, controller states and
// the command/status structs between controller and datapath.
package fmp_pkg;

	localparam int OP_W      = 3;
	localparam int IDX_W     = 6;
	localparam int BND_W     = 11;
	localparam int COORD_W   = 10;
	localparam int CHAN_W    = 5;
	localparam int SAMPLE_W  = 16;
	localparam int DIM_W     = 11;
	localparam int CNT_W     = 7;
	localparam int MASK_W    = 32;
	localparam int CFG_IDX_W = 3;

	// item operations
	localparam logic [OP_W-1:0] OP_LOAD_X = 3'd0;
	localparam logic [OP_W-1:0] OP_LOAD_Y = 3'd1;
	localparam logic [OP_W-1:0] OP_CLEAR  = 3'd2;
	localparam logic [OP_W-1:0] OP_PIXEL  = 3'd3;
	localparam logic [OP_W-1:0] OP_READ   = 3'd4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_IN_WIDTH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IN_HEIGHT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_OVERLAP    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_CHAN_MASK  = 3'd5;

	typedef struct packed {
		logic                       seen;
		logic signed [SAMPLE_W-1:0] value;
		logic [CHAN_W-1:0]          chan;
		logic [COORD_W-1:0]         px;
		logic [COORD_W-1:0]         py;
	} cell_word_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MASK,
		ST_RUN,
		ST_UPD,
		ST_RDQ,
		ST_RDD
	} state_t;

	typedef struct packed {
		logic capture;   // latch item fields
		logic tbl_wr;    // boundary table write
		logic clr_start; // restart sweep counter
		logic sweep;     // clear one cell entry
		logic mask_ld;   // register region hit masks
		logic cell_rd;   // read current pixel cell
		logic cell_upd;  // compare and write current pixel cell
		logic rd_issue;  // read cell for a read item
		logic out_ld;    // load result register
	} ctrl_cmd_t;

	typedef struct packed {
		logic sweep_last;
		logic cells_empty;
		logic last_cell;
		logic out_free;
	} dp_stat_t;

endpackage

// File: sv/fmp_ram.sv
// fmp_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module fmp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: sv/fmp_region.sv
// fmp_region: boundary table of one axis and one match lane per region.
// Depends on fmp_pkg.
module fmp_region import fmp_pkg::*; #(
	parameter int MAX_OUT = 64,
	localparam int OW = $clog2(MAX_OUT),
	localparam int NW = $clog2(MAX_OUT + 1)
) (
	input  logic               clk,
	input  logic               wr_en,
	input  logic [OW-1:0]      wr_idx,
	input  logic [BND_W-1:0]   wr_data,
	input  logic [COORD_W-1:0] coord,
	input  logic [NW-1:0]      count,
	input  logic               overlap,
	output logic [MAX_OUT-1:0] hit
);

	logic [BND_W-1:0] bnd_q [MAX_OUT];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			bnd_q[wr_idx] <= wr_data;
		end
	end

	// lane r: start is the previous boundary, the last live region runs to the edge
	for (genvar r = 0; r < MAX_OUT; r++) begin : g_lane
		logic [BND_W-1:0] lo;
		logic             ge_lo;
		logic             below_hi;
		logic             live;
		logic             is_last;

		if (r == 0) begin : g_first
			assign lo = '0;
		end else begin : g_rest
			assign lo = bnd_q[r-1];
		end

		assign ge_lo    = {1'b0, coord} >= lo;
		assign below_hi = overlap ? ({1'b0, coord} <= bnd_q[r]) : ({1'b0, coord} < bnd_q[r]);
		assign live     = NW'(r) < count;
		assign is_last  = NW'(r + 1) == count;
		assign hit[r]   = live && ge_lo && (is_last || below_hi);
	end

endmodule

// File: sv/fmp_dp.sv
// fmp_dp: datapath - registers, boundary tables, hit masks, cell memory,
// result register. Depends on fmp_pkg, fmp_region, fmp_ram.
module fmp_dp import fmp_pkg::*; #(
	parameter int MAX_OUT      = 64,
	parameter int MAX_IN       = 1024,
	parameter int MAX_CHANNELS = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ctrl_cmd_t                  cmd,
	output dp_stat_t                   stat,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [MASK_W-1:0]          cfg_data,
	input  logic [OP_W-1:0]            item_op,
	input  logic [IDX_W-1:0]           entry_index,
	input  logic [BND_W-1:0]           boundary,
	input  logic [COORD_W-1:0]         pix_x,
	input  logic [COORD_W-1:0]         pix_y,
	input  logic [CHAN_W-1:0]          channel,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic [IDX_W-1:0]           cell_x,
	input  logic [IDX_W-1:0]           cell_y,
	output logic                       result_valid,
	input  logic                       result_stall,
	output logic                       found,
	output logic signed [SAMPLE_W-1:0] max_value,
	output logic [CHAN_W-1:0]          max_channel,
	output logic [COORD_W-1:0]         max_x,
	output logic [COORD_W-1:0]         max_y
);

	localparam int OW    = $clog2(MAX_OUT);
	localparam int NW    = $clog2(MAX_OUT + 1);
	localparam int IW    = $clog2(MAX_IN + 1);
	localparam int DEPTH = MAX_OUT * MAX_OUT;
	localparam int CW    = $clog2(DEPTH);

	// configuration
	logic [DIM_W-1:0]  in_width_q, in_height_q;
	logic [CNT_W-1:0]  out_width_q, out_height_q;
	logic              overlap_q;
	logic [MASK_W-1:0] chan_mask_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_width_q   <= DIM_W'(32);
			in_height_q  <= DIM_W'(32);
			out_width_q  <= CNT_W'(16);
			out_height_q <= CNT_W'(16);
			overlap_q    <= 1'b0;
			chan_mask_q  <= '1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_IN_WIDTH:   in_width_q   <= cfg_data[DIM_W-1:0];
				CFG_IN_HEIGHT:  in_height_q  <= cfg_data[DIM_W-1:0];
				CFG_OUT_WIDTH:  out_width_q  <= cfg_data[CNT_W-1:0];
				CFG_OUT_HEIGHT: out_height_q <= cfg_data[CNT_W-1:0];
				CFG_OVERLAP:    overlap_q    <= cfg_data[0];
				CFG_CHAN_MASK:  chan_mask_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [NW-1:0] nx, ny;
	logic [IW-1:0] wx, hy;

	assign nx = (32'(out_width_q) > 32'(MAX_OUT)) ? NW'(MAX_OUT) : NW'(out_width_q);
	assign ny = (32'(out_height_q) > 32'(MAX_OUT)) ? NW'(MAX_OUT) : NW'(out_height_q);
	assign wx = (32'(in_width_q) > 32'(MAX_IN)) ? IW'(MAX_IN) : IW'(in_width_q);
	assign hy = (32'(in_height_q) > 32'(MAX_IN)) ? IW'(MAX_IN) : IW'(in_height_q);

	// captured item
	logic [COORD_W-1:0]         px_q, py_q;
	logic [CHAN_W-1:0]          ch_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic [IDX_W-1:0]           cx_q, cy_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			px_q     <= pix_x;
			py_q     <= pix_y;
			ch_q     <= channel;
			sample_q <= sample;
			cx_q     <= cell_x;
			cy_q     <= cell_y;
		end
	end

	// boundary tables
	logic               idx_ok;
	logic [MAX_OUT-1:0] xhit, yhit;

	assign idx_ok = 32'(entry_index) < 32'(MAX_OUT);

	fmp_region #(.MAX_OUT(MAX_OUT)) u_xreg (
		.clk     (clk),
		.wr_en   (cmd.tbl_wr && idx_ok && (item_op == OP_LOAD_X)),
		.wr_idx  (OW'(entry_index)),
		.wr_data (boundary),
		.coord   (px_q),
		.count   (nx),
		.overlap (overlap_q),
		.hit     (xhit)
	);

	fmp_region #(.MAX_OUT(MAX_OUT)) u_yreg (
		.clk     (clk),
		.wr_en   (cmd.tbl_wr && idx_ok && (item_op == OP_LOAD_Y)),
		.wr_idx  (OW'(entry_index)),
		.wr_data (boundary),
		.coord   (py_q),
		.count   (ny),
		.overlap (overlap_q),
		.hit     (yhit)
	);

	// pixel eligibility: connected channel, inside the plane
	logic elig;

	assign elig = (32'(ch_q) < 32'(MAX_CHANNELS)) && chan_mask_q[ch_q]
		&& (32'(px_q) < 32'(wx)) && (32'(py_q) < 32'(hy));

	// hit masks; xw_q walks one row of x hits, ym_q the remaining y hits
	logic [MAX_OUT-1:0] xm_q, xw_q, ym_q;
	logic               x_single, y_single;

	assign x_single = (xw_q & (xw_q - 1'b1)) == '0;
	assign y_single = (ym_q & (ym_q - 1'b1)) == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xm_q <= '0;
			xw_q <= '0;
			ym_q <= '0;
		end else if (cmd.mask_ld) begin
			xm_q <= elig ? xhit : '0;
			xw_q <= elig ? xhit : '0;
			ym_q <= (elig && (xhit != '0)) ? yhit : '0;
		end else if (cmd.cell_upd) begin
			if (x_single) begin
				xw_q <= xm_q;
				ym_q <= ym_q & (ym_q - 1'b1);
			end else begin
				xw_q <= xw_q & (xw_q - 1'b1);
			end
		end
	end

	// lowest set bit of each walk mask
	logic [OW-1:0] fx, fy;

	always_comb begin
		fx = '0;
		fy = '0;
		for (int i = MAX_OUT - 1; i >= 0; i--) begin
			if (xw_q[i]) begin
				fx = OW'(i);
			end
			if (ym_q[i]) begin
				fy = OW'(i);
			end
		end
	end

	// cell memory
	logic [CW-1:0] cur_addr, rd_addr, sweep_q;
	logic          rd_in_range;

	assign cur_addr    = CW'(32'(fy) * MAX_OUT) + CW'(fx);
	assign rd_addr     = CW'(32'(OW'(cy_q)) * MAX_OUT) + CW'(OW'(cx_q));
	assign rd_in_range = (32'(cx_q) < 32'(nx)) && (32'(cy_q) < 32'(ny));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
		end else if (cmd.clr_start) begin
			sweep_q <= '0;
		end else if (cmd.sweep) begin
			sweep_q <= sweep_q + 1'b1;
		end
	end

	cell_word_t rd_word, wr_word;
	logic       better;

	assign better = !rd_word.seen || (sample_q > rd_word.value);

	always_comb begin
		wr_word = '0;
		if (!cmd.sweep) begin
			wr_word.seen  = 1'b1;
			wr_word.value = sample_q;
			wr_word.chan  = ch_q;
			wr_word.px    = px_q;
			wr_word.py    = py_q;
		end
	end

	fmp_ram #(.WIDTH($bits(cell_word_t)), .DEPTH(DEPTH)) u_cells (
		.clk   (clk),
		.we    (cmd.sweep || (cmd.cell_upd && better)),
		.waddr (cmd.sweep ? sweep_q : cur_addr),
		.wdata (wr_word),
		.re    (cmd.cell_rd || cmd.rd_issue),
		.raddr (cmd.rd_issue ? rd_addr : cur_addr),
		.rdata (rd_word)
	);

	// result register
	logic                       res_valid_q, found_q;
	logic signed [SAMPLE_W-1:0] value_q;
	logic [CHAN_W-1:0]          chan_q;
	logic [COORD_W-1:0]         x_q, y_q;
	logic                       hit_cell;

	assign hit_cell = rd_word.seen && rd_in_range;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.out_ld) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			found_q <= hit_cell;
			value_q <= hit_cell ? rd_word.value : '0;
			chan_q  <= hit_cell ? rd_word.chan : '0;
			x_q     <= hit_cell ? rd_word.px : '0;
			y_q     <= hit_cell ? rd_word.py : '0;
		end
	end

	assign result_valid = res_valid_q;
	assign found        = found_q;
	assign max_value    = value_q;
	assign max_channel  = chan_q;
	assign max_x        = x_q;
	assign max_y        = y_q;

	assign stat.sweep_last  = sweep_q == CW'(DEPTH - 1);
	assign stat.cells_empty = ym_q == '0;
	assign stat.last_cell   = x_single && y_single;
	assign stat.out_free    = !res_valid_q || !result_stall;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |-> !(res_valid_q && result_stall))
		else $error("result register overwritten while stalled");

	a_rd_has_cell: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cell_rd |-> (ym_q != '0) && (xw_q != '0))
		else $error("cell read with empty hit mask");

	a_upd_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cell_upd |-> $past(cmd.cell_rd))
		else $error("cell update without a preceding read");

endmodule

// File: sv/fmp_ctrl.sv
// fmp_ctrl: controller state machine sequencing items over the datapath.
// Depends on fmp_pkg.
module fmp_ctrl import fmp_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	input  logic [OP_W-1:0] item_op,
	output logic            item_stall,
	input  dp_stat_t        stat,
	output ctrl_cmd_t       cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		item_stall = state_q != ST_IDLE;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.sweep = 1'b1;
				if (stat.sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (item_valid) begin
					cmd.capture = 1'b1;
					unique case (item_op)
						OP_LOAD_X, OP_LOAD_Y: cmd.tbl_wr = 1'b1;
						OP_CLEAR: begin
							cmd.clr_start = 1'b1;
							state_d       = ST_CLEAR;
						end
						OP_PIXEL: state_d = ST_MASK;
						OP_READ:  state_d = ST_RDQ;
						default: ;
					endcase
				end
			end
			ST_MASK: begin
				cmd.mask_ld = 1'b1;
				state_d     = ST_RUN;
			end
			ST_RUN: begin
				if (stat.cells_empty) begin
					state_d = ST_IDLE;
				end else begin
					cmd.cell_rd = 1'b1;
					state_d     = ST_UPD;
				end
			end
			ST_UPD: begin
				cmd.cell_upd = 1'b1;
				state_d      = stat.last_cell ? ST_IDLE : ST_RUN;
			end
			ST_RDQ: begin
				cmd.rd_issue = 1'b1;
				state_d      = ST_RDD;
			end
			ST_RDD: begin
				if (stat.out_free) begin
					cmd.out_ld = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// File: sv/fractional_max_pool_engine_core.sv
// Fractional max pooling engine, one output map. A boundary load is taken from idle. A
// pixel registers its hit masks, then reads and compare-writes each touched cell (x hits
// times y hits). A read issues, waits while a stalled result is held, then loads the
// result register and frees the item side. Clear and reset: a pass over MAX_OUT*MAX_OUT
// cell entries, one per cycle, item_stall high meanwhile; config writes are always taken.
module fractional_max_pool_engine_core import fmp_pkg::*; #(
	parameter int MAX_OUT      = 64,
	parameter int MAX_IN       = 1024,
	parameter int MAX_CHANNELS = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// config write channel
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [MASK_W-1:0]          cfg_data,
	// item channel: one beat is one op
	input  logic                       item_valid,
	output logic                       item_stall,
	input  logic [OP_W-1:0]            item_op,
	input  logic [IDX_W-1:0]           entry_index,
	input  logic [BND_W-1:0]           boundary,
	input  logic [COORD_W-1:0]         pix_x,
	input  logic [COORD_W-1:0]         pix_y,
	input  logic [CHAN_W-1:0]          channel,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic [IDX_W-1:0]           cell_x,
	input  logic [IDX_W-1:0]           cell_y,
	// result channel: one beat per read op
	output logic                       result_valid,
	input  logic                       result_stall,
	output logic                       found,
	output logic signed [SAMPLE_W-1:0] max_value,
	output logic [CHAN_W-1:0]          max_channel,
	output logic [COORD_W-1:0]         max_x,
	output logic [COORD_W-1:0]         max_y
);

	// Controller walks the ops; datapath holds tables, hit masks and the
	// cell memory. A pixel visits each hit cell with a read then a
	// compare-and-write, so the memory port sets the per-cell cost.
	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	fmp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_op    (item_op),
		.item_stall (item_stall),
		.stat       (stat),
		.cmd        (cmd)
	);

	fmp_dp #(
		.MAX_OUT      (MAX_OUT),
		.MAX_IN       (MAX_IN),
		.MAX_CHANNELS (MAX_CHANNELS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_op      (item_op),
		.entry_index  (entry_index),
		.boundary     (boundary),
		.pix_x        (pix_x),
		.pix_y        (pix_y),
		.channel      (channel),
		.sample       (sample),
		.cell_x       (cell_x),
		.cell_y       (cell_y),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.found        (found),
		.max_value    (max_value),
		.max_channel  (max_channel),
		.max_x        (max_x),
		.max_y        (max_y)
	);

endmodule
